// ----- rtl/spr_pkg.sv -----
package spr_pkg;

    localparam int unsigned ACT_W   = 2;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned CNT_RST = 64;
    localparam int unsigned MAX_PARTICLES = 64;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD     = 2'd0,
        ACT_RESAMPLE = 2'd1,
        ACT_READ     = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_MEAN = 1'b1;

    // one particle record as kept in the stores
    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] yaw;
        logic [DATA_W-1:0] weight;
    } particle_t;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DATA_W+31:0] mag;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    // divider status
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W+31:0] quot;
    } div_rsp_t;

endpackage

// ----- rtl/systematic_particle_resampler.sv -----
// channel  | dir | tdata fields (low bit up)                                   | tuser
// s_axis   | in  | index, pos_x, pos_y, pos_z, yaw, weight, offset_fraction     | action
// m_axis   | out | out_x, out_y, out_z, out_yaw, out_weight                     | kind
// cfg      | in  | particle_count, written when cfg_we is high                  | -
//
// load and unknown actions end in the accepting state; a read goes through accept, memory read and result
// resample, with S the steps along the cumulative weights (at most N-1), runs
// one reciprocal and four means on the one shared bit-serial divider,
// a compare and a copy state per point, and a compare and an add state per step
// reset returns state to idle, clears bank select and sets the count to 64; the stores stay undefined
// the input is not ready while an item is at work or a result waits; an output stall holds the result state
module systematic_particle_resampler
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [231:0] s_axis_tdata,  // index[5:0], pos_x, pos_y, pos_z, yaw, weight, frac
    input  logic [1:0]   s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,  // out_x, out_y, out_z, out_yaw, out_weight
    output logic         m_axis_tuser   // kind
);
    import spr_pkg::*;

    localparam int unsigned AW = $clog2(2 * MAX_PARTICLES);
    localparam int unsigned SW = AW - 1;
    localparam int unsigned NW = $clog2(MAX_PARTICLES + 1);
    localparam int unsigned ACC_W = DATA_W + NW + 1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_READ  = 9'b000000010,
        ST_FETCH = 9'b000000100,
        ST_CMP   = 9'b000001000,
        ST_COPY  = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_WAIT  = 9'b001000000,
        ST_OUT   = 9'b010000000,
        ST_ADD   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // particle store, both banks
    particle_t mem [2*MAX_PARTICLES];
    particle_t rd_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    particle_t     wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    logic [CNT_W-1:0] count_reg;
    logic             bank_reg;
    logic [5:0]       index_in;
    logic [1:0]       action_in;
    logic [DATA_W-1:0] frac_reg;
    logic [NW-1:0]    n_val;
    logic [NW-1:0]    m_reg, i_reg;
    logic [DATA_W+NW-1:0] cum_reg;
    logic [ACC_W-1:0] sum_reg [4];
    logic [1:0]       dsel_reg;
    logic [DATA_W-1:0] mean_reg [4];
    logic [DATA_W-1:0] factor;
    logic             oob_reg, kind_reg;
    div_req_t         dreq;
    div_rsp_t         drsp;
    logic [DATA_W+NW+31:0] point, cumn;
    logic [ACC_W-1:0] sel_sum, sel_mag;

    assign index_in  = s_axis_tdata[5:0];
    assign action_in = s_axis_tuser;

    always_comb
    begin
        if (count_reg == '0)
            n_val = NW'(1);
        else if (32'(count_reg) > MAX_PARTICLES)
            n_val = NW'(MAX_PARTICLES);
        else
            n_val = NW'(count_reg);
    end

    spr_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // 1/N from the shared divider before the walk, then the four means
    logic [DATA_W-1:0] factor_reg;
    logic              fac_pass_reg;
    assign factor = factor_reg;

    assign point = {NW'(0), 32'(m_reg), frac_reg} + {{(NW+32){1'b0}}, 32'(0)};
    assign cumn  = (DATA_W+NW+32)'(cum_reg) * (DATA_W+NW+32)'(n_val);

    always_comb
    begin
        sel_sum = sum_reg[dsel_reg];
        sel_mag = sel_sum[ACC_W-1] ? (~sel_sum + ACC_W'(1)) : sel_sum;
    end

    always_comb
    begin
        state_next = state_reg;
        we    = 1'b0;
        waddr = '0;
        raddr = {bank_reg, i_reg[SW-1:0]};
        wdata = rd_reg;
        dreq  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                raddr = {bank_reg, index_in[SW-1:0]};
                if (s_axis_tvalid)
                begin
                    case (action_in)
                        ACT_LOAD:
                        begin
                            if (32'(index_in) < MAX_PARTICLES)
                            begin
                                we    = 1'b1;
                                waddr = {bank_reg, index_in[SW-1:0]};
                                wdata = particle_t'({s_axis_tdata[37:6], s_axis_tdata[69:38],
                                                     s_axis_tdata[101:70], s_axis_tdata[133:102],
                                                     s_axis_tdata[165:134]});
                            end
                        end
                        ACT_READ:     state_next = ST_READ;
                        ACT_RESAMPLE: state_next = ST_FETCH;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:  state_next = ST_OUT;
            ST_FETCH:
            begin
                // reciprocal 1/N first
                dreq.start   = 1'b1;
                dreq.divisor = CNT_W'(n_val);
                dreq.mag     = 64'h1_0000_0000;
                state_next   = ST_WAIT;
            end
            ST_ADD:   state_next = ST_CMP;
            ST_CMP:
            begin
                if (point > cumn && 32'(i_reg) + 1 < 32'(n_val))
                begin
                    raddr      = {bank_reg, SW'(i_reg + NW'(1))};
                    state_next = ST_ADD;
                end
                else
                    state_next = ST_COPY;
            end
            ST_COPY:
            begin
                we           = 1'b1;
                waddr        = {~bank_reg, m_reg[SW-1:0]};
                wdata        = rd_reg;
                wdata.weight = factor;
                if (32'(m_reg) + 1 >= 32'(n_val))
                    state_next = ST_DIV;
                else
                    state_next = ST_CMP;
            end
            ST_DIV:
            begin
                dreq.start   = 1'b1;
                dreq.divisor = CNT_W'(n_val);
                dreq.neg     = sel_sum[ACC_W-1];
                dreq.mag     = 64'(sel_mag) + 64'(n_val >> 1);
                state_next   = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (drsp.done)
                begin
                    if (fac_pass_reg)
                        state_next = ST_ADD;
                    else
                        state_next = (dsel_reg != 2'd3) ? ST_DIV : ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= CNT_W'(CNT_RST);
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                count_reg <= cfg_data;
            if (state_reg == ST_WAIT && drsp.done && !fac_pass_reg && dsel_reg == 2'd3)
                bank_reg <= ~bank_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                oob_reg         <= !(32'(index_in) < MAX_PARTICLES);
                kind_reg        <= (action_in == ACT_RESAMPLE) ? KIND_MEAN : KIND_READ;
                frac_reg        <= s_axis_tdata[DATA_W*6+5:DATA_W*5+6];
                m_reg           <= '0;
                // a read keeps its slot addressed until the result is taken
                i_reg           <= (action_in == ACT_READ) ? NW'(index_in) : '0;
                cum_reg         <= '0;
                dsel_reg        <= '0;
                fac_pass_reg    <= 1'b1;
                for (int k = 0; k < 4; k++)
                    sum_reg[k] <= '0;
            end
            ST_FETCH:
            begin
                // reciprocal first, done before the walk
            end
            ST_ADD:
            begin
                cum_reg <= cum_reg + (DATA_W+NW)'(rd_reg.weight);
            end
            ST_CMP:
            begin
                if (point > cumn && 32'(i_reg) + 1 < 32'(n_val))
                    i_reg <= i_reg + NW'(1);
            end
            ST_COPY:
            begin
                m_reg      <= m_reg + NW'(1);
                sum_reg[0] <= sum_reg[0] + ACC_W'($signed(rd_reg.x));
                sum_reg[1] <= sum_reg[1] + ACC_W'($signed(rd_reg.y));
                sum_reg[2] <= sum_reg[2] + ACC_W'($signed(rd_reg.z));
                sum_reg[3] <= sum_reg[3] + ACC_W'($signed(rd_reg.yaw));
            end
            ST_WAIT:
            begin
                if (drsp.done)
                begin
                    if (fac_pass_reg)
                    begin
                        factor_reg   <= (n_val == NW'(1)) ? '1 : drsp.quot[DATA_W-1:0];
                        fac_pass_reg <= 1'b0;
                    end
                    else
                    begin
                        mean_reg[dsel_reg] <= drsp.quot[DATA_W-1:0];
                        dsel_reg           <= dsel_reg + 2'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tuser  = kind_reg;

    always_comb
    begin
        if (kind_reg == KIND_MEAN)
            m_axis_tdata = {factor_reg, mean_reg[3], mean_reg[2], mean_reg[1], mean_reg[0]};
        else if (oob_reg)
            m_axis_tdata = '0;
        else
            m_axis_tdata = {rd_reg.weight, rd_reg.yaw, rd_reg.z, rd_reg.y, rd_reg.x};
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");
    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> (state_reg == ST_OUT))
        else $error("bank swapped outside resample end");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> (32'(i_reg) < 32'(n_val)))
        else $error("walk beyond last particle");
`endif

endmodule

// ----- rtl/spr_divider.sv -----
module spr_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  spr_pkg::div_req_t req,
    output spr_pkg::div_rsp_t rsp
);
    import spr_pkg::*;

    localparam int unsigned QW = DATA_W + 32;

    logic [QW-1:0]    quot_reg, quot_next;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg, dvs_next;
    logic [6:0]       bit_reg, bit_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    logic [CNT_W:0]   trial;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        trial     = {rem_reg[CNT_W-1:0], quot_reg[QW-1]};
        if (req.start)
        begin
            quot_next = req.mag;
            rem_next  = '0;
            dvs_next  = req.divisor;
            bit_next  = 7'(QW - 1);
            busy_next = 1'b1;
            neg_next  = req.neg;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[QW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next     = trial - {1'b0, dvs_reg};
                quot_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            if (bit_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            bit_next = bit_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        bit_reg  <= bit_next;
        neg_reg  <= neg_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? (~quot_reg + QW'(1)) : quot_reg;

endmodule
